@@ hdl/ppdf_pkg.sv @@
// shared types, constants and register map of the ipv4 packet pattern drop filter
package ppdf_pkg;

    // pattern window
    localparam int MAX_PATTERN_BYTES = 8;
    localparam int WINDOW_BITS       = 8 * MAX_PATTERN_BYTES;
    localparam int LEN_BITS          = 4;
    localparam int LEN_IDX_BITS      = $clog2(MAX_PATTERN_BYTES);

    // header layout
    localparam int HEADER_BYTES    = 20;
    localparam int PROTOCOL_OFFSET = 9;
    localparam int SOURCE_FIRST    = 12;
    localparam int SOURCE_LAST     = 15;
    localparam int COUNT_BITS      = $clog2(HEADER_BYTES + 1);

    // configuration port
    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_ADDRESS = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PROTOCOL_CODE  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MATCH_PATTERN  = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_MATCH_LENGTH   = 2'd3;

    // register reset values
    localparam logic [31:0]          RST_SOURCE_ADDRESS = 32'h0A01_0001;
    localparam logic [7:0]           RST_PROTOCOL_CODE  = 8'd6;
    localparam logic [WINDOW_BITS-1:0] RST_MATCH_PATTERN =
        WINDOW_BITS'(64'h0000_0048_5045_5453);
    localparam logic [LEN_BITS-1:0]  RST_MATCH_LENGTH   = 4'd5;

    // configuration seen by the datapath
    typedef struct packed {
        logic [31:0]            source_address;
        logic [7:0]             protocol_code;
        logic [WINDOW_BITS-1:0] match_pattern;
        logic [LEN_BITS-1:0]    match_length;
    } cfg_t;

endpackage

@@ hdl/ipv4_packet_pattern_drop_filter_top.sv @@
// top level: input register, per-packet state, verdict register and config port
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata = packet_byte, s_tlast = last_byte
//  m_*       out  m_tvalid / m_tready       m_tdata = drop, header_matched, pattern_found
//  apb       in   psel, penable, pready     paddr / pwdata / prdata, registers at 8*i
//
// one byte per cycle sustained unless a waiting verdict stalls the input; a byte is held
// in the input register and its window compare and header capture finish while it is held,
// so the verdict register is loaded as the last byte leaves the input register.
// synchronous active-low reset clears the control flags and packet state.
// a waiting verdict only stalls the input when the byte held in the input register is also a last byte.
module ipv4_packet_pattern_drop_filter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // packet byte stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] packet_byte
    input  logic                               s_tlast,
    // verdict stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [0] drop, [1] header_matched,
                                                          // [2] pattern_found, [7:3] zero
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppdf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ppdf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ppdf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import ppdf_pkg::*;

    cfg_t cfg;

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic [WINDOW_BITS-1:0] window_reg, window_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [31:0]            source_reg, source_next;
    logic [7:0]             protocol_reg, protocol_next;
    logic                   found_reg, found_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   drop_reg, header_reg, pattern_reg;
    logic [WINDOW_BITS-1:0] window_shift;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   hit;
    logic                   header_ok;
    logic                   advance;

    ppdf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the held byte moves on unless it is a last byte and the verdict slot is busy
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // window shift and saturating byte position (saturates past the header)
    assign window_shift = {window_reg[WINDOW_BITS-9:0], in_byte_reg};
    assign count_inc    = (count_reg == COUNT_BITS'(HEADER_BYTES)) ? count_reg
                                                                  : count_reg + COUNT_BITS'(1);

    ppdf_match u_match (
        .window  (window_shift),
        .count   (count_inc),
        .pattern (cfg.match_pattern),
        .length  (cfg.match_length),
        .hit     (hit)
    );

    // header capture from the byte position before this byte
    always_comb begin
        protocol_next = protocol_reg;
        source_next   = source_reg;
        if (count_reg == COUNT_BITS'(PROTOCOL_OFFSET))
            protocol_next = in_byte_reg;
        if (count_reg >= COUNT_BITS'(SOURCE_FIRST) && count_reg <= COUNT_BITS'(SOURCE_LAST))
            source_next = {source_reg[23:0], in_byte_reg};
    end

    assign header_ok = (count_inc == COUNT_BITS'(HEADER_BYTES))
                       && (source_next == cfg.source_address)
                       && (protocol_next == cfg.protocol_code);

    // per-packet state, cleared after the last byte
    always_comb begin
        window_next = window_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        if (advance) begin
            if (in_last_reg) begin
                window_next = '0;
                count_next  = '0;
                found_next  = 1'b0;
            end else begin
                window_next = window_shift;
                count_next  = count_inc;
                found_next  = found_reg || hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            count_reg    <= '0;
            source_reg   <= '0;
            protocol_reg <= '0;
            found_reg    <= 1'b0;
        end else begin
            window_reg <= window_next;
            count_reg  <= count_next;
            found_reg  <= found_next;
            if (advance) begin
                source_reg   <= in_last_reg ? 32'd0 : source_next;
                protocol_reg <= in_last_reg ? 8'd0 : protocol_next;
            end
        end
    end

    // verdict register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            pattern_reg <= found_reg || hit;
            header_reg  <= header_ok;
            drop_reg    <= header_ok && (found_reg || hit);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, pattern_reg, header_reg, drop_reg};

endmodule

@@ hdl/ppdf_cfg.sv @@
// apb register file holding the filter configuration
module ppdf_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppdf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ppdf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ppdf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output ppdf_pkg::cfg_t                     cfg
);
    import ppdf_pkg::*;

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:APB_ADDR_BITS-REG_IDX_BITS];
    assign wr_en   = psel && penable && pwrite && pready;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SOURCE_ADDRESS: cfg_next.source_address = pwdata[31:0];
                REG_PROTOCOL_CODE:  cfg_next.protocol_code  = pwdata[7:0];
                REG_MATCH_PATTERN:  cfg_next.match_pattern  = pwdata[WINDOW_BITS-1:0];
                REG_MATCH_LENGTH:   cfg_next.match_length   = pwdata[LEN_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_address <= RST_SOURCE_ADDRESS;
            cfg_reg.protocol_code  <= RST_PROTOCOL_CODE;
            cfg_reg.match_pattern  <= RST_MATCH_PATTERN;
            cfg_reg.match_length   <= RST_MATCH_LENGTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_SOURCE_ADDRESS: prdata = APB_DATA_BITS'(cfg_reg.source_address);
            REG_PROTOCOL_CODE:  prdata = APB_DATA_BITS'(cfg_reg.protocol_code);
            REG_MATCH_PATTERN:  prdata = APB_DATA_BITS'(cfg_reg.match_pattern);
            REG_MATCH_LENGTH:   prdata = APB_DATA_BITS'(cfg_reg.match_length);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/ppdf_match.sv @@
// parallel compare of the byte window against the configured pattern
module ppdf_match (
    input  logic [ppdf_pkg::WINDOW_BITS-1:0] window,
    input  logic [ppdf_pkg::COUNT_BITS-1:0]  count,
    input  logic [ppdf_pkg::WINDOW_BITS-1:0] pattern,
    input  logic [ppdf_pkg::LEN_BITS-1:0]    length,
    output logic                             hit
);
    import ppdf_pkg::*;

    logic [LEN_BITS-1:0]          len_eff;
    logic [LEN_IDX_BITS-1:0]      len_idx;
    logic [MAX_PATTERN_BYTES-1:0] len_hit;

    // zero acts as one, anything above the window acts as the full window
    always_comb begin
        if (length == '0)
            len_eff = LEN_BITS'(1);
        else if (length > LEN_BITS'(MAX_PATTERN_BYTES))
            len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
        else
            len_eff = length;
    end

    // candidate match for every pattern length, pattern byte 0 is the oldest
    always_comb begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            len_hit[k] = 1'b1;
            for (int i = 0; i <= k; i++) begin
                if (pattern[8*i +: 8] != window[8*(k-i) +: 8])
                    len_hit[k] = 1'b0;
            end
        end
    end

    assign len_idx = LEN_IDX_BITS'(len_eff - LEN_BITS'(1));
    assign hit     = (COUNT_BITS'(len_eff) <= count) && len_hit[len_idx];

endmodule

@@ tb/ppdf_verdict_checker.sv @@
`timescale 1ns / 100ps
// verdict checker: follows the byte stream and register port, predicts and compares verdicts
module ppdf_verdict_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [7:0]                         s_tdata,          // [7:0] packet_byte
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [7:0]                         m_tdata,          // [0] drop, [1] header_matched,
                                                                 // [2] pattern_found
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [ppdf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ppdf_pkg::APB_DATA_BITS-1:0] pwdata,
    output int                                 mismatch_count,
    output int                                 verdicts_pending
);
    import ppdf_pkg::*;

    typedef struct {
        logic drop;
        logic header_matched;
        logic pattern_found;
    } verdict_t;

    // filter settings as last written through the register port
    logic [31:0]            filter_source;
    logic [7:0]             filter_protocol;
    logic [WINDOW_BITS-1:0] filter_pattern;
    logic [LEN_BITS-1:0]    filter_length;

    // per-packet state
    logic [WINDOW_BITS-1:0] byte_window;
    logic [15:0]            byte_count;
    logic [31:0]            captured_source;
    logic [7:0]             captured_protocol;
    logic                   pattern_seen;

    verdict_t               expected_verdicts[$];
    verdict_t               oldest;
    int                     errors = 0;

    task automatic clear_packet();
        byte_window       = '0;
        byte_count        = '0;
        captured_source   = '0;
        captured_protocol = '0;
        pattern_seen      = 1'b0;
    endtask

    // length 0 behaves as 1, anything above the window as the full window
    function automatic int pattern_bytes_in_use();
        if (filter_length == 0) return 1;
        if (filter_length > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
        return int'(filter_length);
    endfunction

    // pattern byte 0 is the oldest of the last n bytes
    function automatic logic pattern_ends_here(int n);
        for (int i = 0; i < n; i++) begin
            if (filter_pattern[8*i +: 8] != byte_window[8*(n-1-i) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the packet state by one byte, queue a verdict on the last one
    task automatic take_byte(logic [7:0] value, logic last);
        verdict_t verdict;
        int       n;
        logic     header_ok;
        n = pattern_bytes_in_use();
        if (byte_count == PROTOCOL_OFFSET) captured_protocol = value;
        if (byte_count >= SOURCE_FIRST && byte_count <= SOURCE_LAST)
            captured_source = {captured_source[23:0], value};
        byte_window = {byte_window[WINDOW_BITS-9:0], value};
        if (byte_count != 16'hFFFF) byte_count = byte_count + 16'd1;
        if (byte_count >= n && pattern_ends_here(n)) pattern_seen = 1'b1;
        if (last) begin
            header_ok = (byte_count >= HEADER_BYTES) && (captured_source == filter_source)
                        && (captured_protocol == filter_protocol);
            verdict.drop           = header_ok && pattern_seen;
            verdict.header_matched = header_ok;
            verdict.pattern_found  = pattern_seen;
            expected_verdicts.push_back(verdict);
            clear_packet();
        end
    endtask

    task automatic check_field(string name, logic expected_bit, logic actual_bit);
        if (expected_bit !== actual_bit) begin
            $error("%s: expected %0b, got %0b", name, expected_bit, actual_bit);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            filter_source   = RST_SOURCE_ADDRESS;
            filter_protocol = RST_PROTOCOL_CODE;
            filter_pattern  = RST_MATCH_PATTERN;
            filter_length   = RST_MATCH_LENGTH;
            clear_packet();
            expected_verdicts.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_BITS-1:3])
                    REG_SOURCE_ADDRESS: filter_source   = pwdata[31:0];
                    REG_PROTOCOL_CODE:  filter_protocol = pwdata[7:0];
                    REG_MATCH_PATTERN:  filter_pattern  = pwdata[WINDOW_BITS-1:0];
                    REG_MATCH_LENGTH:   filter_length   = pwdata[LEN_BITS-1:0];
                    default: ;
                endcase
            end
            // packet byte transaction
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
            // verdict transaction
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("verdict 0x%0h arrived with no packet outstanding", m_tdata);
                    errors++;
                end else begin
                    oldest = expected_verdicts.pop_front();
                    check_field("drop", oldest.drop, m_tdata[0]);
                    check_field("header_matched", oldest.header_matched, m_tdata[1]);
                    check_field("pattern_found", oldest.pattern_found, m_tdata[2]);
                end
            end
        end
        mismatch_count   <= errors;
        verdicts_pending <= expected_verdicts.size();
    end

endmodule

@@ tb/ipv4_packet_pattern_drop_filter_top_test.sv @@
`timescale 1ns / 100ps
// testbench top: clock, reset, packet and register stimulus, run verdict
module ipv4_packet_pattern_drop_filter_top_test;
    import ppdf_pkg::*;

    localparam int IDLE_LIMIT        = 4000;
    localparam int SETTLE_CYCLES     = 8;
    localparam int BYTES_PER_PHASE   = 180;
    localparam int LONG_PACKET_BYTES = 128;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [7:0]               s_tdata  = '0;
    logic                     s_tlast  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [7:0]               m_tdata;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr    = '0;
    logic [APB_DATA_BITS-1:0] pwdata   = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int                       mismatch_count;
    int                       verdicts_pending;

    // filter settings the stimulus aims at
    logic [31:0]              cur_source   = RST_SOURCE_ADDRESS;
    logic [7:0]               cur_protocol = RST_PROTOCOL_CODE;
    logic [63:0]              cur_pattern  = RST_MATCH_PATTERN;
    logic [3:0]               cur_length   = RST_MATCH_LENGTH;

    logic [7:0]               packet_bytes[$];
    int                       burst_left   = 0;
    int                       idle_cycles  = 0;
    int                       ready_hold   = 0;
    ready_mode_t              ready_mode   = READY_ALWAYS;

    ipv4_packet_pattern_drop_filter_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ppdf_verdict_checker verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // verdict receiver stalls in randomly chosen modes that change after a random hold
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_hold = $urandom_range(20, 300);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
            default:      m_tready <= (ready_hold % 8) < 3;
        endcase
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ipv4_packet_pattern_drop_filter_top_test: done, errors");
            $finish;
        end
    end

    function automatic int pattern_bytes_in_use();
        if (cur_length == 0) return 1;
        if (cur_length > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
        return int'(cur_length);
    endfunction

    task automatic fill_random(int count);
        packet_bytes.delete();
        repeat (count) packet_bytes.push_back(8'($urandom));
    endtask

    // protocol and source address at their header offsets, first source byte on top
    task automatic put_header(logic [31:0] src, logic [7:0] proto);
        packet_bytes[PROTOCOL_OFFSET] = proto;
        for (int i = 0; i < 4; i++) packet_bytes[SOURCE_FIRST + i] = src[31 - 8*i -: 8];
    endtask

    task automatic put_pattern(int pos, int count);
        for (int i = 0; i < count; i++) packet_bytes[pos + i] = cur_pattern[8*i +: 8];
    endtask

    // one byte transaction; bursts of random length with random gaps
    task automatic send_byte(logic [7:0] value, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_packet();
        foreach (packet_bytes[i]) send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
    endtask

    // stop sending, let every verdict arrive, then give the pipeline time to empty
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup then access cycle; psel stays up for a following write
    task automatic write_register(logic [REG_IDX_BITS-1:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    // unused upper bits of pwdata carry junk
    task automatic set_filter(logic [31:0] src, logic [7:0] proto, logic [63:0] pat,
                              logic [3:0] len);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_register(REG_SOURCE_ADDRESS, {junk[63:32], src});
        write_register(REG_PROTOCOL_CODE, {junk[63:8], proto});
        write_register(REG_MATCH_PATTERN, pat);
        write_register(REG_MATCH_LENGTH, {junk[63:4], len});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_source   = src;
        cur_protocol = proto;
        cur_pattern  = pat;
        cur_length   = len;
    endtask

    // mostly well-formed packets aimed at the filter, plus noise and short packets
    task automatic run_random_phase(logic [31:0] src, logic [7:0] proto, logic [63:0] pat,
                                    logic [3:0] len);
        int sent;
        int kind;
        int count;
        int n;
        sent = 0;
        set_filter(src, proto, pat, len);
        n = pattern_bytes_in_use();
        while (sent < BYTES_PER_PHASE) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                fill_random($urandom_range(1, HEADER_BYTES - 1));
            end else if (kind == 1) begin
                // short packet that still carries the pattern
                count = $urandom_range(n, HEADER_BYTES - 1);
                fill_random(count);
                put_pattern($urandom_range(0, count - n), n);
            end else if (kind == 2) begin
                fill_random($urandom_range(HEADER_BYTES, 48));
            end else begin
                count = $urandom_range(HEADER_BYTES, 64);
                fill_random(count);
                put_header(($urandom_range(0, 9) == 0)
                               ? cur_source ^ (32'd1 << $urandom_range(0, 31)) : cur_source,
                           ($urandom_range(0, 9) == 0)
                               ? cur_protocol ^ (8'd1 << $urandom_range(0, 7)) : cur_protocol);
                case ($urandom_range(0, 3))
                    0: ;
                    1: put_pattern($urandom_range(0, count - n), n - 1);
                    default: put_pattern($urandom_range(0, count - n), n);
                endcase
            end
            send_packet();
            sent += packet_bytes.size();
        end
        drain_verdicts();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset settings: one-byte packet, short packet with the pattern,
        // minimal packet with matching header and pattern
        packet_bytes = '{8'hFF};
        send_packet();
        fill_random(5);
        put_pattern(0, 5);
        send_packet();
        packet_bytes.delete();
        repeat (HEADER_BYTES) packet_bytes.push_back(8'h00);
        put_header(cur_source, cur_protocol);
        put_pattern(0, 5);
        send_packet();
        drain_verdicts();

        // extremes of every register, then random settings
        run_random_phase(32'h0, 8'h00, 64'h0, 4'd1);
        run_random_phase(32'hFFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        run_random_phase($urandom, 8'($urandom), {$urandom, $urandom}, 4'd0);
        run_random_phase($urandom, 8'($urandom), {$urandom, $urandom}, 4'd15);
        run_random_phase($urandom, 8'($urandom), {$urandom, $urandom}, 4'd9);
        repeat (4)
            run_random_phase($urandom, 8'($urandom), {$urandom, $urandom},
                             4'($urandom_range(1, MAX_PATTERN_BYTES)));

        // packet well past the header, pattern at its very end
        fill_random(LONG_PACKET_BYTES);
        put_header(cur_source, cur_protocol);
        put_pattern(LONG_PACKET_BYTES - pattern_bytes_in_use(), pattern_bytes_in_use());
        send_packet();
        drain_verdicts();

        if (mismatch_count == 0)
            $display("ipv4_packet_pattern_drop_filter_top_test: done, clean");
        else
            $display("ipv4_packet_pattern_drop_filter_top_test: done, errors");
        $finish;
    end

endmodule
